[hw/rtl/json_value_extent_scanner_defines.svh]
// Assertion macros used by the checker file of the value extent scanner.
`ifndef JSON_VALUE_EXTENT_SCANNER_DEFINES_SVH
`define JSON_VALUE_EXTENT_SCANNER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define JVES_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define JVES_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/jves_pkg.sv]
`default_nettype none

package jves_pkg;

    // Counter widths
    localparam int DEPTH_BITS  = 16;
    localparam int LENGTH_BITS = 16;

    // Result type codes
    localparam logic [2:0] VT_STRING  = 3'd0;
    localparam logic [2:0] VT_OBJECT  = 3'd1;
    localparam logic [2:0] VT_ARRAY   = 3'd2;
    localparam logic [2:0] VT_TRUE    = 3'd3;
    localparam logic [2:0] VT_FALSE   = 3'd4;
    localparam logic [2:0] VT_NULL    = 3'd5;
    localparam logic [2:0] VT_INTEGER = 3'd6;
    localparam logic [2:0] VT_FLOAT   = 3'd7;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_RECOG = 2'd1;
    localparam logic [1:0] ST_DEPTH_OVF = 2'd2;
    localparam logic [1:0] ST_LEN_OVF   = 2'd3;

    // Literal lengths
    localparam logic [2:0] LEN_TRUE  = 3'd4;
    localparam logic [2:0] LEN_FALSE = 3'd5;
    localparam logic [2:0] LEN_NULL  = 3'd4;

    // Literal selectors
    localparam logic [1:0] LIT_TRUE  = 2'd0;
    localparam logic [1:0] LIT_FALSE = 2'd1;
    localparam logic [1:0] LIT_NULL  = 2'd2;

    // Characters
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_POINT  = 8'h2E;
    localparam logic [7:0] CH_LOW_E  = 8'h65;
    localparam logic [7:0] CH_UP_E   = 8'h45;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;

    // Number flag bit positions
    localparam int NF_SIGN  = 0;
    localparam int NF_POINT = 1;
    localparam int NF_EXP   = 2;
    localparam int NF_DIGIT = 3;

    // Letter of a literal at a position
    function automatic logic [7:0] lit_char(input logic [1:0] sel, input logic [2:0] idx);
        logic [39:0] text;
        begin
            unique case (sel)
                LIT_TRUE:  text = {8'h74, 8'h72, 8'h75, 8'h65, 8'h00};
                LIT_FALSE: text = {8'h66, 8'h61, 8'h6C, 8'h73, 8'h65};
                LIT_NULL:  text = {8'h6E, 8'h75, 8'h6C, 8'h6C, 8'h00};
                default:   text = '0;
            endcase
            unique case (idx)
                3'd0:    lit_char = text[39:32];
                3'd1:    lit_char = text[31:24];
                3'd2:    lit_char = text[23:16];
                3'd3:    lit_char = text[15:8];
                3'd4:    lit_char = text[7:0];
                default: lit_char = 8'h00;
            endcase
        end
    endfunction

    function automatic logic [2:0] lit_len(input logic [1:0] sel);
        begin
            unique case (sel)
                LIT_TRUE:  lit_len = LEN_TRUE;
                LIT_FALSE: lit_len = LEN_FALSE;
                LIT_NULL:  lit_len = LEN_NULL;
                default:   lit_len = 3'd0;
            endcase
        end
    endfunction

endpackage

`default_nettype wire

[hw/rtl/jves_in_if.sv]
`default_nettype none

// Text byte channel
interface jves_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       window_end;

    modport source (output valid, output text_byte, output window_end, input ready);
    modport sink   (input valid, input text_byte, input window_end, output ready);
endinterface

`default_nettype wire

[hw/rtl/jves_out_if.sv]
`default_nettype none

// Result channel
interface jves_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  value_type;
    logic [15:0] value_length;
    logic [1:0]  status;

    modport source (output valid, output value_type, output value_length, output status,
                    input ready);
    modport sink   (input valid, input value_type, input value_length, input status,
                    output ready);
endinterface

`default_nettype wire

[hw/rtl/json_value_extent_scanner.sv]
// Path: the byte that completes a result word passes from the input register through the
// scan step into the result register.
// Throughput: one byte per cycle; the combinational scan step between the input
// register and the result register sets that figure, and stalls only on output backpressure.
// Reset (rst_n low, asynchronous): scan returns to idle with all counters and flags clear,
// and both the input and result registers are emptied.
`default_nettype none

module json_value_extent_scanner (
    input  wire          clk,
    input  wire          rst_n,
    jves_in_if.sink      text_in,
    jves_out_if.source   result_out
);
    import jves_pkg::*;

    typedef enum logic [2:0] {
        K_IDLE   = 3'd0,
        K_STRING = 3'd1,
        K_OBJECT = 3'd2,
        K_ARRAY  = 3'd3,
        K_TRUE   = 3'd4,
        K_FALSE  = 3'd5,
        K_NULL   = 3'd6,
        K_NUMBER = 3'd7
    } kind_t;

    localparam logic [DEPTH_BITS-1:0]  MAX_DEPTH  = {DEPTH_BITS{1'b1}};
    localparam logic [LENGTH_BITS-1:0] MAX_LENGTH = {LENGTH_BITS{1'b1}};

    // Input stage
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_end_reg;

    // Scan state
    kind_t                  kind_reg, kind_next;
    logic [DEPTH_BITS-1:0]  depth_reg, depth_next;
    logic                   in_str_reg, in_str_next;
    logic                   bslash_reg, bslash_next;
    logic [LENGTH_BITS-1:0] count_reg, count_next;
    logic [3:0]             nflags_reg, nflags_next;
    logic [2:0]             lit_idx_reg, lit_idx_next;
    logic                   done_reg, done_next;

    // Result register
    logic        out_valid_reg;
    logic [2:0]  out_type_reg, out_type_next;
    logic [15:0] out_len_reg, out_len_next;
    logic [1:0]  out_status_reg, out_status_next;

    logic advance;
    logic emit;

    assign advance        = s1_valid_reg && (!out_valid_reg || result_out.ready);
    assign text_in.ready  = !s1_valid_reg || advance;

    assign result_out.valid        = out_valid_reg;
    assign result_out.value_type   = out_type_reg;
    assign result_out.value_length = out_len_reg;
    assign result_out.status       = out_status_reg;

    // One scan step on the registered byte
    always_comb
    begin
        kind_t                  k;
        logic [DEPTH_BITS-1:0]  d;
        logic                   ins;
        logic                   bs;
        logic [LENGTH_BITS-1:0] cnt;
        logic [3:0]             nf;
        logic [3:0]             f;
        logic [2:0]             li;
        logic [1:0]             st;
        logic                   em;
        logic                   bad;
        logic                   term;
        logic [7:0]             c;
        logic [7:0]             open_ch;
        logic [7:0]             close_ch;
        logic [1:0]             lsel;
        logic [2:0]             llen;
        logic                   num_path;

        c   = s1_byte_reg;
        k   = kind_reg;
        d   = depth_reg;
        ins = in_str_reg;
        bs  = bslash_reg;
        cnt = count_reg;
        nf  = nflags_reg;
        li  = lit_idx_reg;
        st  = ST_OK;
        em  = 1'b0;
        bad = 1'b0;
        term = 1'b0;
        f   = nflags_reg;
        num_path = 1'b0;
        open_ch  = (kind_reg == K_OBJECT) ? CH_LBRACE : CH_LBRACK;
        close_ch = (kind_reg == K_OBJECT) ? CH_RBRACE : CH_RBRACK;
        lsel = (kind_reg == K_FALSE) ? LIT_FALSE : ((kind_reg == K_NULL) ? LIT_NULL : LIT_TRUE);
        llen = lit_len(lsel);

        if (!done_reg)
        begin
            unique case (kind_reg)
                K_IDLE:
                begin
                    cnt = LENGTH_BITS'(1);
                    if (c == CH_QUOTE)
                    begin
                        k = K_STRING;
                    end
                    else if (c == CH_LBRACE)
                    begin
                        k = K_OBJECT;
                        d = DEPTH_BITS'(1);
                    end
                    else if (c == CH_LBRACK)
                    begin
                        k = K_ARRAY;
                        d = DEPTH_BITS'(1);
                    end
                    else if (c == CH_LOW_T)
                    begin
                        k  = K_TRUE;
                        li = 3'd1;
                    end
                    else if (c == CH_LOW_F)
                    begin
                        k  = K_FALSE;
                        li = 3'd1;
                    end
                    else if (c == CH_LOW_N)
                    begin
                        k  = K_NULL;
                        li = 3'd1;
                    end
                    else
                    begin
                        // counters are clear while idle
                        k   = K_NUMBER;
                        cnt = count_reg;
                        num_path = 1'b1;
                    end
                end
                K_STRING:
                begin
                    if (count_reg == MAX_LENGTH)
                    begin
                        em = 1'b1;
                        st = ST_LEN_OVF;
                    end
                    else
                    begin
                        cnt = count_reg + 1'b1;
                        if (c == CH_QUOTE && !bslash_reg)
                        begin
                            em = 1'b1;
                        end
                        else
                        begin
                            bs = (c == CH_BSLASH) && !bslash_reg;
                        end
                    end
                end
                K_OBJECT, K_ARRAY:
                begin
                    if (count_reg == MAX_LENGTH)
                    begin
                        em = 1'b1;
                        st = ST_LEN_OVF;
                    end
                    else
                    begin
                        cnt = count_reg + 1'b1;
                        if (in_str_reg)
                        begin
                            if (c == CH_QUOTE && !bslash_reg)
                            begin
                                ins = 1'b0;
                                bs  = 1'b0;
                            end
                            else
                            begin
                                bs = (c == CH_BSLASH) && !bslash_reg;
                            end
                        end
                        else if (c == CH_QUOTE)
                        begin
                            ins = 1'b1;
                            bs  = 1'b0;
                        end
                        else if (c == open_ch)
                        begin
                            if (depth_reg == MAX_DEPTH)
                            begin
                                em = 1'b1;
                                st = ST_DEPTH_OVF;
                            end
                            else
                            begin
                                d = depth_reg + 1'b1;
                            end
                        end
                        else if (c == close_ch)
                        begin
                            d = depth_reg - 1'b1;
                            if (d == '0)
                            begin
                                em = 1'b1;
                            end
                        end
                    end
                end
                K_TRUE, K_FALSE, K_NULL:
                begin
                    if (lit_idx_reg >= llen || lit_char(lsel, lit_idx_reg) != c)
                    begin
                        em = 1'b1;
                        st = ST_NOT_RECOG;
                    end
                    else
                    begin
                        li  = lit_idx_reg + 1'b1;
                        cnt = LENGTH_BITS'(li);
                        if (li == llen)
                        begin
                            em = 1'b1;
                        end
                    end
                end
                default:
                begin
                    num_path = 1'b1;
                end
            endcase

            // Number byte: signs, point, exponent, digits, terminators
            if (num_path)
            begin
                if (c == CH_PLUS || c == CH_MINUS)
                begin
                    bad = nflags_reg[NF_SIGN];
                    f[NF_SIGN] = 1'b1;
                end
                else if (c == CH_POINT)
                begin
                    bad = nflags_reg[NF_POINT];
                    f[NF_POINT] = 1'b1;
                end
                else if (c == CH_LOW_E || c == CH_UP_E)
                begin
                    bad = nflags_reg[NF_EXP];
                    f[NF_EXP]  = 1'b1;
                    f[NF_SIGN] = 1'b0;
                end
                else if (c >= CH_ZERO && c <= CH_NINE)
                begin
                    f[NF_DIGIT] = 1'b1;
                end
                else if (c == CH_SPACE || c == CH_LF || c == CH_TAB || c == CH_FF ||
                         c == CH_SEMI || c == CH_COMMA || c == CH_RBRACK || c == CH_RBRACE)
                begin
                    term = 1'b1;
                end
                else
                begin
                    bad = 1'b1;
                end

                if (bad)
                begin
                    em = 1'b1;
                    st = ST_NOT_RECOG;
                end
                else if (term)
                begin
                    em = 1'b1;
                    st = nflags_reg[NF_DIGIT] ? ST_OK : ST_NOT_RECOG;
                end
                else if (count_reg == MAX_LENGTH)
                begin
                    em = 1'b1;
                    st = ST_LEN_OVF;
                end
                else
                begin
                    cnt = count_reg + 1'b1;
                    nf  = f;
                end
            end

            // Window closes with the scan still open
            if (s1_end_reg && !em)
            begin
                em = 1'b1;
                st = (k == K_NUMBER && nf[NF_DIGIT]) ? ST_OK : ST_NOT_RECOG;
            end
        end

        emit = em;

        // Result word
        unique case (k)
            K_STRING: out_type_next = VT_STRING;
            K_OBJECT: out_type_next = VT_OBJECT;
            K_ARRAY:  out_type_next = VT_ARRAY;
            K_TRUE:   out_type_next = VT_TRUE;
            K_FALSE:  out_type_next = VT_FALSE;
            K_NULL:   out_type_next = VT_NULL;
            default:  out_type_next = (nf[NF_POINT] || nf[NF_EXP]) ? VT_FLOAT : VT_INTEGER;
        endcase
        out_len_next    = 16'(cnt);
        out_status_next = st;
        if (st == ST_NOT_RECOG)
        begin
            out_type_next = VT_STRING;
            out_len_next  = '0;
        end

        // Next scan state; the marked byte returns everything to idle
        if (s1_end_reg)
        begin
            kind_next    = K_IDLE;
            depth_next   = '0;
            in_str_next  = 1'b0;
            bslash_next  = 1'b0;
            count_next   = '0;
            nflags_next  = '0;
            lit_idx_next = '0;
            done_next    = 1'b0;
        end
        else
        begin
            kind_next    = k;
            depth_next   = d;
            in_str_next  = ins;
            bslash_next  = bs;
            count_next   = cnt;
            nflags_next  = nf;
            lit_idx_next = li;
            done_next    = done_reg || em;
        end
    end

    // State, input stage control and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            kind_reg      <= K_IDLE;
            depth_reg     <= '0;
            in_str_reg    <= 1'b0;
            bslash_reg    <= 1'b0;
            count_reg     <= '0;
            nflags_reg    <= '0;
            lit_idx_reg   <= '0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (text_in.valid && text_in.ready)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                kind_reg    <= kind_next;
                depth_reg   <= depth_next;
                in_str_reg  <= in_str_next;
                bslash_reg  <= bslash_next;
                count_reg   <= count_next;
                nflags_reg  <= nflags_next;
                lit_idx_reg <= lit_idx_next;
                done_reg    <= done_next;
            end

            if (advance && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (text_in.valid && text_in.ready)
        begin
            s1_byte_reg <= text_in.text_byte;
            s1_end_reg  <= text_in.window_end;
        end
        if (advance && emit)
        begin
            out_type_reg   <= out_type_next;
            out_len_reg    <= out_len_next;
            out_status_reg <= out_status_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/jves_checker.sv]
`default_nettype none
`include "json_value_extent_scanner_defines.svh"

module jves_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        out_valid,
    input wire        out_ready,
    input wire [2:0]  value_type,
    input wire [15:0] value_length,
    input wire [1:0]  status
);
    import jves_pkg::*;

    // A stalled result word stays offered
    `JVES_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")

    // Unrecognized values carry no type or length
    `JVES_ASSERT_NOW(a_nr_zero, clk, rst_n, out_valid && status == ST_NOT_RECOG, value_type == VT_STRING && value_length == 16'd0, "unrecognized result has type or length")

    // Finished literals have their exact spelled length
    `JVES_ASSERT_NOW(a_lit_len, clk, rst_n, out_valid && status == ST_OK && (value_type == VT_TRUE || value_type == VT_NULL || value_type == VT_FALSE), value_length == ((value_type == VT_FALSE) ? 16'd5 : 16'd4), "literal length mismatch")

    // Closed strings, objects and arrays include both delimiters
    `JVES_ASSERT_NOW(a_delim_len, clk, rst_n, out_valid && status == ST_OK && (value_type == VT_STRING || value_type == VT_OBJECT || value_type == VT_ARRAY), value_length >= 16'd2, "delimited value too short")

endmodule

bind json_value_extent_scanner jves_checker u_jves_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (result_out.valid),
    .out_ready    (result_out.ready),
    .value_type   (result_out.value_type),
    .value_length (result_out.value_length),
    .status       (result_out.status)
);

`default_nettype wire
